[hdl/sre_pkg.sv]
// Shared types and constants of the scaler readout rate engine.
package sre_pkg;

  // Channel-count field of the module header word
  localparam logic [31:0] CHAN_FIELD_MASK = 32'h0000_00f0;
  // Milliseconds per second, multiplier of the fixed time base
  localparam logic [31:0] MS_PER_S        = 32'd1000;
  // Q.16 saturation limits
  localparam logic [47:0] RATE_POS_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] RATE_NEG_MIN    = 48'h8000_0000_0000;
  // Quotient bits left after the saturation check
  localparam int unsigned QBITS           = 47;

  // Configuration register reset values
  localparam logic [31:0] HEADER_VALUE_RST  = 32'd0;
  localparam logic [31:0] HEADER_MASK_RST   = 32'd0;
  localparam logic [5:0]  CLOCK_CHANNEL_RST = 6'd32;
  localparam logic [31:0] CLOCK_RATE_RST    = 32'd0;
  localparam logic [15:0] DELTA_T_RST       = 16'd4000;

  typedef enum logic [2:0] {
    CFG_HEADER_VALUE  = 3'd0,
    CFG_HEADER_MASK   = 3'd1,
    CFG_CLOCK_CHANNEL = 3'd2,
    CFG_CLOCK_RATE_HZ = 3'd3,
    CFG_DELTA_T_MS    = 3'd4
  } cfg_idx_e;

  typedef logic [1:0] bank_t;

  // One finished capture handed from front to back
  typedef struct packed {
    logic  rate_ok;
    logic  mismatch;
    bank_t bank;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CLK_RD,
    B_CLK_WAIT,
    B_CH_RD,
    B_CH_DIFF,
    B_MUL,
    B_SAT,
    B_DIV,
    B_SIGN,
    B_OUT
  } back_state_e;

endpackage

[hdl/sre_if.sv]
// Valid/ready channel interfaces for input words and channel results.
interface sre_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        event_start;

  modport source (output valid, word, event_start, input ready);
  modport sink   (input valid, word, event_start, output ready);
endinterface

interface sre_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         channel;
  logic [31:0]        count;
  logic signed [47:0] rate;
  logic               rate_valid;
  logic               channel_count_error;
  logic               last;

  modport source (output valid, channel, count, rate, rate_valid, channel_count_error, last,
                  input ready);
  modport sink   (input valid, channel, count, rate, rate_valid, channel_count_error, last,
                  output ready);
endinterface

[hdl/sre_ram.sv]
// Generic RAM: one write port, two registered read ports.
module sre_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [W-1:0]  rdata_a_o,
  output logic [W-1:0]  rdata_b_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_a_q;
  logic [W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hdl/sre_front.sv]
// Front end: header detection and capture of channel counts into the bank RAM.
module sre_front import sre_pkg::*; #(
  parameter int N     = 32,
  localparam int IW   = (N > 1) ? $clog2(N) : 1,
  localparam int AW   = IW + 2,
  localparam int CNTW = $clog2(N + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sre_in_if.sink        in_s,
  input  logic [31:0]   hdr_value_i,
  input  logic [31:0]   hdr_mask_i,
  input  logic          hold_i,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [31:0]   ram_wdata_o,
  output logic          push_o,
  output job_t          job_o
);

  logic            capturing_q, capturing_d;
  logic            decoded_q, decoded_d;
  logic            first_q, first_d;
  logic            mismatch_q, mismatch_d;
  bank_t           bank_q, bank_d;
  logic [CNTW-1:0] idx_q, idx_d;
  logic            acc;
  logic            hdr_hit;
  logic            last_word;

  // Count words wait while two captures are still owned by the back end
  assign in_s.ready = !(capturing_q && hold_i);
  assign acc        = in_s.valid && in_s.ready;
  assign hdr_hit    = (in_s.word & hdr_mask_i) == hdr_value_i;
  assign last_word  = idx_q == CNTW'(N - 1);

  always_comb begin
    logic dec;
    dec         = decoded_q;
    capturing_d = capturing_q;
    decoded_d   = decoded_q;
    first_d     = first_q;
    mismatch_d  = mismatch_q;
    bank_d      = bank_q;
    idx_d       = idx_q;
    ram_we_o    = 1'b0;
    push_o      = 1'b0;
    if (acc) begin
      dec       = in_s.event_start ? 1'b0 : decoded_q;
      decoded_d = dec;
      if (!capturing_q) begin
        if (!dec && hdr_hit) begin
          decoded_d   = 1'b1;
          mismatch_d  = (in_s.word & CHAN_FIELD_MASK) != 32'(N);
          // new bank keeps the last snapshot as previous
          if (!first_q) begin
            bank_d = bank_q + 2'd1;
          end
          capturing_d = 1'b1;
          idx_d       = '0;
        end
      end else begin
        ram_we_o = 1'b1;
        if (last_word) begin
          capturing_d = 1'b0;
          idx_d       = '0;
          push_o      = 1'b1;
          first_d     = 1'b0;
        end else begin
          idx_d = idx_q + CNTW'(1);
        end
      end
    end
  end

  assign ram_waddr_o = {bank_q, idx_q[IW-1:0]};
  assign ram_wdata_o = in_s.word;
  assign job_o       = '{rate_ok: !first_q, mismatch: mismatch_q, bank: bank_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      decoded_q   <= 1'b0;
      first_q     <= 1'b1;
      mismatch_q  <= 1'b0;
      bank_q      <= '0;
      idx_q       <= '0;
    end else begin
      capturing_q <= capturing_d;
      decoded_q   <= decoded_d;
      first_q     <= first_d;
      mismatch_q  <= mismatch_d;
      bank_q      <= bank_d;
      idx_q       <= idx_d;
    end
  end

endmodule

[hdl/sre_job_fifo.sv]
// Two-entry queue of finished captures between front and back.
module sre_job_fifo import sre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output job_t       job_o,
  output logic       not_empty_o,
  output logic [1:0] count_o
);

  job_t       slot_q [2];
  logic [1:0] count_q;
  logic [1:0] after_pop;

  assign after_pop = count_q - (pop_i ? 2'd1 : 2'd0);

  // Payload shifts toward the head on pop; a push lands behind what remains
  always_ff @(posedge clk_i) begin
    if (push_i && (after_pop == 2'd0)) begin
      slot_q[0] <= job_i;
    end else if (pop_i) begin
      slot_q[0] <= slot_q[1];
    end
    if (push_i && (after_pop != 2'd0)) begin
      slot_q[1] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= after_pop + (push_i ? 2'd1 : 2'd0);
    end
  end

  assign job_o       = slot_q[0];
  assign not_empty_o = count_q != 2'd0;
  assign count_o     = count_q;

endmodule

[hdl/sre_back.sv]
// Back end: per-channel difference, scaling and serial Q.16 division.
module sre_back import sre_pkg::*; #(
  parameter int N   = 32,
  localparam int IW = (N > 1) ? $clog2(N) : 1,
  localparam int AW = IW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  job_t          job_i,
  output logic          pop_o,
  output logic          busy_o,
  input  logic [5:0]    clock_channel_i,
  input  logic [31:0]   clock_rate_i,
  input  logic [15:0]   delta_t_i,
  output logic [AW-1:0] raddr_cur_o,
  output logic [AW-1:0] raddr_prev_o,
  input  logic [31:0]   rdata_cur_i,
  input  logic [31:0]   rdata_prev_i,
  sre_out_if.source     out_m
);

  localparam int NOUT = (N < 32) ? N : 32;

  back_state_e     state_q, state_d;
  job_t            job_q;
  logic [IW-1:0]   c_q;
  logic [31:0]     den_q;
  logic            den_neg_q;
  logic            zero_q;
  logic [31:0]     mult_q;
  logic [31:0]     count_q;
  logic [31:0]     mag_q;
  logic            neg_q;
  logic [63:0]     num_q;
  logic [31:0]     rem_q;
  logic [QBITS-1:0] div_q;
  logic [5:0]      step_q;
  logic [47:0]     rate_q;

  logic            out_vld_q;
  logic [4:0]      o_chan_q;
  logic [31:0]     o_count_q;
  logic [47:0]     o_rate_q;
  logic            o_rvalid_q;
  logic            o_err_q;
  logic            o_last_q;

  logic            use_clock;
  logic [IW-1:0]   rd_idx;
  logic [31:0]     diff;
  logic            dneg;
  logic [31:0]     dmag;
  logic            sat;
  logic [32:0]     trial;
  logic            ge;
  logic [32:0]     trial_sub;
  logic            skip;
  logic            is_last;
  logic            load;

  assign use_clock = (clock_rate_i != 32'd0) && ({1'b0, clock_channel_i} < 7'(N));
  assign diff      = rdata_cur_i - rdata_prev_i;
  assign dneg      = diff[31];
  assign dmag      = dneg ? (~diff + 32'd1) : diff;
  // quotient would reach 2^31 integer counts per second
  assign sat       = num_q >= {1'b0, den_q, 31'd0};
  assign trial     = {rem_q, div_q[QBITS-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  assign skip      = !job_q.rate_ok || zero_q;
  assign is_last   = c_q == IW'(NOUT - 1);
  assign load      = (state_q == B_OUT) && (!out_vld_q || out_m.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:     if (job_valid_i) state_d = use_clock ? B_CLK_RD : B_CH_RD;
      B_CLK_RD:   state_d = B_CLK_WAIT;
      B_CLK_WAIT: state_d = B_CH_RD;
      B_CH_RD:    state_d = B_CH_DIFF;
      B_CH_DIFF:  state_d = skip ? B_OUT : B_MUL;
      B_MUL:      state_d = B_SAT;
      B_SAT:      state_d = sat ? B_OUT : B_DIV;
      B_DIV:      if (step_q == 6'd0) state_d = B_SIGN;
      B_SIGN:     state_d = B_OUT;
      B_OUT:      if (load) state_d = is_last ? B_IDLE : B_CH_RD;
      default:    state_d = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o  = (state_q == B_IDLE) && job_valid_i;
    busy_o = state_q != B_IDLE;
    rd_idx = (state_q == B_CLK_RD) ? clock_channel_i[IW-1:0] : c_q;
  end

  assign raddr_cur_o  = {job_q.bank, rd_idx};
  assign raddr_prev_o = {job_q.bank - 2'd1, rd_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_m.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_q     <= job_i;
          c_q       <= '0;
          mult_q    <= use_clock ? clock_rate_i : MS_PER_S;
          den_q     <= 32'(delta_t_i);
          den_neg_q <= 1'b0;
          zero_q    <= delta_t_i == 16'd0;
        end
      end
      B_CLK_WAIT: begin
        den_q     <= dmag;
        den_neg_q <= dneg;
        zero_q    <= diff == 32'd0;
      end
      B_CH_DIFF: begin
        count_q <= rdata_cur_i;
        mag_q   <= dmag;
        neg_q   <= dneg ^ den_neg_q;
        rate_q  <= '0;
      end
      B_MUL: begin
        num_q <= mag_q * mult_q;
      end
      B_SAT: begin
        if (sat) begin
          rate_q <= neg_q ? RATE_NEG_MIN : RATE_POS_MAX;
        end else begin
          rem_q  <= num_q[62:31];
          div_q  <= {num_q[30:0], 16'd0};
          step_q <= 6'(QBITS - 1);
        end
      end
      B_DIV: begin
        rem_q  <= ge ? trial_sub[31:0] : trial[31:0];
        div_q  <= {div_q[QBITS-2:0], ge};
        step_q <= step_q - 6'd1;
      end
      B_SIGN: begin
        rate_q <= neg_q ? (48'd0 - {1'b0, div_q}) : {1'b0, div_q};
      end
      B_OUT: begin
        if (load && !is_last) begin
          c_q <= c_q + IW'(1);
        end
      end
      default: ;
    endcase
    if (load) begin
      o_chan_q   <= 5'(c_q);
      o_count_q  <= count_q;
      o_rate_q   <= rate_q;
      o_rvalid_q <= job_q.rate_ok;
      o_err_q    <= job_q.mismatch;
      o_last_q   <= is_last;
    end
  end

  assign out_m.valid               = out_vld_q;
  assign out_m.channel             = o_chan_q;
  assign out_m.count               = o_count_q;
  assign out_m.rate                = o_rate_q;
  assign out_m.rate_valid          = o_rvalid_q;
  assign out_m.channel_count_error = o_err_q;
  assign out_m.last                = o_last_q;

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !o_rvalid_q |-> o_rate_q == 48'd0)
    else $error("rate not zero on an invalid result");
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && o_last_q |-> o_chan_q == 5'(NOUT - 1))
    else $error("last flag on a wrong channel");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> rem_q < den_q)
    else $error("division remainder out of range");
`endif

endmodule

[hdl/scaler_readout_rate_engine.sv]
// Top level of the scaler readout rate engine.
//
// in_s carries event-buffer words (word, event_start); a word is taken when
// valid and ready are both high. A header word matching header_value under
// header_mask opens a capture of the next NUM_CHANNELS words. After the last
// count word, one result per channel (up to 32) leaves on out_m with count,
// signed Q.16 rate, rate_valid, channel_count_error and last on the final one.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle,
// a rule for the user that the block itself does not enforce. A capture takes
// one count word per cycle while ready is high. A computed rate passes the
// read, difference, multiply, saturation, one-bit-per-cycle restoring divider
// (47 steps), sign and output steps; a saturated result skips the divider and
// sign, and a zero or invalid one goes from difference straight to output. One
// finished capture may wait in the queue while the back end works on another;
// beyond that, count words are held off with ready low.
// Reset clears all control state; count RAM needs no clearing, since every
// entry whose value is used was written by a capture. A stalled receiver
// holds the output register and the back end waits.
module scaler_readout_rate_engine import sre_pkg::*; #(
  parameter int NUM_CHANNELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  sre_in_if.sink      in_s,
  sre_out_if.source   out_m
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW = IW + 2;

  logic [31:0]   hdr_value_q;
  logic [31:0]   hdr_mask_q;
  logic [5:0]    clock_channel_q;
  logic [31:0]   clock_rate_q;
  logic [15:0]   delta_t_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] raddr_cur;
  logic [AW-1:0] raddr_prev;
  logic [31:0]   rdata_cur;
  logic [31:0]   rdata_prev;
  logic          push;
  job_t          job_in;
  job_t          job_head;
  logic          job_valid;
  logic [1:0]    job_count;
  logic          pop;
  logic          busy;
  logic          hold;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_value_q     <= HEADER_VALUE_RST;
      hdr_mask_q      <= HEADER_MASK_RST;
      clock_channel_q <= CLOCK_CHANNEL_RST;
      clock_rate_q    <= CLOCK_RATE_RST;
      delta_t_q       <= DELTA_T_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_VALUE:  hdr_value_q     <= cfg_data_i;
        CFG_HEADER_MASK:   hdr_mask_q      <= cfg_data_i;
        CFG_CLOCK_CHANNEL: clock_channel_q <= cfg_data_i[5:0];
        CFG_CLOCK_RATE_HZ: clock_rate_q    <= cfg_data_i;
        CFG_DELTA_T_MS:    delta_t_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Two captures in flight occupy three of the four banks
  assign hold = ({1'b0, job_count} + {2'b00, busy}) >= 3'd2;

  sre_ram #(
    .W     (32),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_cur),
    .raddr_b_i (raddr_prev),
    .rdata_a_o (rdata_cur),
    .rdata_b_o (rdata_prev)
  );

  sre_front #(
    .N (NUM_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_s),
    .hdr_value_i (hdr_value_q),
    .hdr_mask_i  (hdr_mask_q),
    .hold_i      (hold),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .push_o      (push),
    .job_o       (job_in)
  );

  sre_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job_in),
    .pop_i       (pop),
    .job_o       (job_head),
    .not_empty_o (job_valid),
    .count_o     (job_count)
  );

  sre_back #(
    .N (NUM_CHANNELS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job_head),
    .pop_o           (pop),
    .busy_o          (busy),
    .clock_channel_i (clock_channel_q),
    .clock_rate_i    (clock_rate_q),
    .delta_t_i       (delta_t_q),
    .raddr_cur_o     (raddr_cur),
    .raddr_prev_o    (raddr_prev),
    .rdata_cur_i     (rdata_cur),
    .rdata_prev_i    (rdata_prev),
    .out_m           (out_m)
  );

endmodule
